[rtl/usbhp_pkg.sv]
// Package for the USB hub port controller.
// Holds the request/response structs, command, feature and status codes,
// and the one-hot port mode encoding. No dependencies.
package usbhp_pkg;

   // widths and defaults
   localparam int PORT_COUNT_DEFAULT = 4;
   localparam int SETTLE_W           = 20;
   localparam int CSR_INDEX_W        = 1;
   localparam int CSR_DATA_W         = 20;
   localparam int CHG_W              = 5;
   localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(10 * 1000);

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HUB_CONFIGURED = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_TICKS   = 1'b1;

   // command codes
   localparam logic [3:0] CMD_SET_FEATURE   = 4'd0;
   localparam logic [3:0] CMD_CLEAR_FEATURE = 4'd1;
   localparam logic [3:0] CMD_PORT_STATUS   = 4'd2;
   localparam logic [3:0] CMD_HUB_REQUEST   = 4'd3;
   localparam logic [3:0] CMD_HUB_STATUS    = 4'd4;
   localparam logic [3:0] CMD_CHANGE_MAP    = 4'd5;
   localparam logic [3:0] CMD_SET_CONFIG    = 4'd6;
   localparam logic [3:0] CMD_TICK          = 4'd7;
   localparam logic [3:0] CMD_SET_CHANGE    = 4'd8;
   localparam logic [3:0] CMD_ATTACH        = 4'd9;

   // feature selectors
   localparam logic [7:0] FEAT_ENABLE        = 8'd1;
   localparam logic [7:0] FEAT_SUSPEND       = 8'd2;
   localparam logic [7:0] FEAT_RESET         = 8'd4;
   localparam logic [7:0] FEAT_POWER         = 8'd8;
   localparam logic [7:0] FEAT_C_CONNECT     = 8'd16;
   localparam logic [7:0] FEAT_C_ENABLE      = 8'd17;
   localparam logic [7:0] FEAT_C_SUSPEND     = 8'd18;
   localparam logic [7:0] FEAT_C_OVERCURRENT = 8'd19;
   localparam logic [7:0] FEAT_C_RESET       = 8'd20;

   // change bit positions
   localparam int CHG_CONNECT     = 0;
   localparam int CHG_ENABLE      = 1;
   localparam int CHG_SUSPEND     = 2;
   localparam int CHG_OVERCURRENT = 3;
   localparam int CHG_RESET       = 4;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_NOTSUP  = 2'd2;

   // port modes, one-hot
   typedef enum logic [7:0] {
      MODE_NOT_CONFIGURED = 8'b0000_0001,
      MODE_POWERED_OFF    = 8'b0000_0010,
      MODE_DISCONNECTED   = 8'b0000_0100,
      MODE_DISABLED       = 8'b0000_1000,
      MODE_RESETTING      = 8'b0001_0000,
      MODE_ENABLED        = 8'b0010_0000,
      MODE_SUSPENDED      = 8'b0100_0000,
      MODE_RESUMING       = 8'b1000_0000
   } mode_type;

   typedef struct packed {
      logic [3:0] command;
      logic [7:0] feature;
      logic [7:0] port_number;
      logic [4:0] change_mask;
      logic       attached_flag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status_code;
      logic [31:0] read_data;
   } rsp_type;

   // operation broadcast to all ports for one request
   typedef struct packed {
      logic             set_feature;
      logic             clear_feature;
      logic             set_config;
      logic             tick;
      logic             set_change;
      logic             attach;
      logic [7:0]       feature;
      logic [CHG_W-1:0] change_mask;
      logic             attached_flag;
   } port_op_type;

   // state reported back by one port
   typedef struct packed {
      logic [31:0] status_word;
      logic        any_change;
   } port_stat_type;

endpackage

[rtl/usbhp_port.sv]
// One downstream hub port: mode machine, change bits, attached flag and
// settle timer. Depends on usbhp_pkg.
module usbhp_port (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [usbhp_pkg::SETTLE_W-1:0]    settle_ticks,
   input  logic                              sel,
   input  usbhp_pkg::port_op_type            op,
   output usbhp_pkg::port_stat_type          stat
);

   usbhp_pkg::mode_type                     mode_ff, mode_in;
   logic [usbhp_pkg::CHG_W-1:0]             chg_ff, chg_in;
   logic                                    att_ff, att_in;
   logic [usbhp_pkg::SETTLE_W-1:0]          cnt_ff, cnt_in;
   logic [usbhp_pkg::SETTLE_W-1:0]          load_value;

   // zero settle time counts as one tick
   assign load_value = (settle_ticks == '0) ? usbhp_pkg::SETTLE_W'(1) : settle_ticks;

   // work out the next port state for this request
   always_comb begin
      mode_in = mode_ff;
      chg_in  = chg_ff;
      att_in  = att_ff;
      cnt_in  = cnt_ff;
      if (op.set_config) begin
         mode_in = usbhp_pkg::MODE_POWERED_OFF;
         chg_in[usbhp_pkg::CHG_CONNECT] = 1'b0;
         chg_in[usbhp_pkg::CHG_ENABLE]  = 1'b0;
         chg_in[usbhp_pkg::CHG_RESET]   = 1'b0;
      end else if (op.tick) begin
         if (mode_ff == usbhp_pkg::MODE_RESETTING || mode_ff == usbhp_pkg::MODE_RESUMING) begin
            if (cnt_ff <= usbhp_pkg::SETTLE_W'(1)) begin
               cnt_in  = '0;
               mode_in = usbhp_pkg::MODE_ENABLED;
               if (mode_ff == usbhp_pkg::MODE_RESETTING) begin
                  chg_in[usbhp_pkg::CHG_RESET] = 1'b1;
               end
            end else begin
               cnt_in = cnt_ff - usbhp_pkg::SETTLE_W'(1);
            end
         end
      end else if (sel && op.set_feature) begin
         case (op.feature)
            usbhp_pkg::FEAT_RESET: begin
               if (mode_ff != usbhp_pkg::MODE_POWERED_OFF) begin
                  mode_in = usbhp_pkg::MODE_RESETTING;
                  cnt_in  = load_value;
               end
            end
            usbhp_pkg::FEAT_SUSPEND: begin
               if (mode_ff == usbhp_pkg::MODE_ENABLED) begin
                  mode_in = usbhp_pkg::MODE_SUSPENDED;
               end
            end
            usbhp_pkg::FEAT_POWER: begin
               if (mode_ff == usbhp_pkg::MODE_POWERED_OFF) begin
                  mode_in = usbhp_pkg::MODE_DISCONNECTED;
               end
            end
            default: begin
            end
         endcase
      end else if (sel && op.clear_feature) begin
         case (op.feature)
            usbhp_pkg::FEAT_ENABLE: begin
               if (mode_ff != usbhp_pkg::MODE_NOT_CONFIGURED &&
                   mode_ff != usbhp_pkg::MODE_POWERED_OFF) begin
                  mode_in = usbhp_pkg::MODE_DISABLED;
               end
            end
            usbhp_pkg::FEAT_SUSPEND: begin
               if (mode_ff == usbhp_pkg::MODE_SUSPENDED) begin
                  mode_in = usbhp_pkg::MODE_RESUMING;
                  cnt_in  = load_value;
               end
            end
            usbhp_pkg::FEAT_POWER: begin
               if (mode_ff != usbhp_pkg::MODE_NOT_CONFIGURED) begin
                  mode_in = usbhp_pkg::MODE_POWERED_OFF;
                  chg_in[usbhp_pkg::CHG_CONNECT] = 1'b0;
                  chg_in[usbhp_pkg::CHG_ENABLE]  = 1'b0;
                  chg_in[usbhp_pkg::CHG_RESET]   = 1'b0;
               end
            end
            usbhp_pkg::FEAT_C_CONNECT:     chg_in[usbhp_pkg::CHG_CONNECT]     = 1'b0;
            usbhp_pkg::FEAT_C_ENABLE:      chg_in[usbhp_pkg::CHG_ENABLE]      = 1'b0;
            usbhp_pkg::FEAT_C_SUSPEND:     chg_in[usbhp_pkg::CHG_SUSPEND]     = 1'b0;
            usbhp_pkg::FEAT_C_OVERCURRENT: chg_in[usbhp_pkg::CHG_OVERCURRENT] = 1'b0;
            usbhp_pkg::FEAT_C_RESET:       chg_in[usbhp_pkg::CHG_RESET]       = 1'b0;
            default: begin
            end
         endcase
      end else if (sel && op.set_change) begin
         chg_in = chg_ff | op.change_mask;
      end else if (sel && op.attach) begin
         att_in = op.attached_flag;
      end
   end

   // hold port state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= usbhp_pkg::MODE_NOT_CONFIGURED;
         chg_ff  <= '0;
         att_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         chg_ff  <= chg_in;
         att_ff  <= att_in;
         cnt_ff  <= cnt_in;
      end
   end

   // build the port status word
   always_comb begin
      stat.status_word        = '0;
      stat.status_word[0]     = att_ff;
      stat.status_word[1]     = (mode_ff == usbhp_pkg::MODE_ENABLED);
      stat.status_word[2]     = (mode_ff == usbhp_pkg::MODE_SUSPENDED) ||
                                (mode_ff == usbhp_pkg::MODE_RESUMING);
      stat.status_word[4]     = (mode_ff == usbhp_pkg::MODE_RESETTING);
      stat.status_word[8]     = (mode_ff != usbhp_pkg::MODE_POWERED_OFF);
      stat.status_word[20:16] = chg_ff;
      stat.any_change         = |chg_ff;
   end

endmodule

[rtl/usb_hub_port_controller.sv]
// A request is held in the input register, and its response is held in the response register.
// Throughput: one request per cycle; the input register feeds a single pass of port
// logic that writes the response register, stalling only while a response waits.
// Reset (synchronous): ports not configured, change bits, attached flags and timers
// cleared, hub_configured 0, settle_ticks 10000; no clearing pass.
// Depends on usbhp_pkg and usbhp_port.
module usb_hub_port_controller #(
   parameter int PORT_COUNT = usbhp_pkg::PORT_COUNT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  usbhp_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output usbhp_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_we,
   input  logic [usbhp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [usbhp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                              hub_cfg_ff;
   logic [usbhp_pkg::SETTLE_W-1:0]    settle_ff;
   usbhp_pkg::req_type                req_ff;
   logic                              req_valid_ff, req_valid_in;
   usbhp_pkg::rsp_type                rsp_ff, rsp_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              advance;
   logic [PORT_COUNT-1:0]             port_hit;
   logic                              port_ok;
   usbhp_pkg::port_op_type            op;
   usbhp_pkg::port_stat_type          stat [PORT_COUNT];
   logic [31:0]                       sel_word;
   logic [31:0]                       port_chg_map;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hub_cfg_ff <= 1'b0;
         settle_ff  <= usbhp_pkg::SETTLE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            usbhp_pkg::CSR_HUB_CONFIGURED: hub_cfg_ff <= csr_wdata[0];
            usbhp_pkg::CSR_SETTLE_TICKS:   settle_ff  <= csr_wdata[usbhp_pkg::SETTLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // process the held request when the response register is empty or its response is taken
   assign advance      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = req_valid_ff && !advance;
   assign req_valid_in = req_stall ? 1'b1 : req_valid;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
   end

   // decode port number and the operation for the ports
   always_comb begin
      for (int i = 0; i < PORT_COUNT; i++) begin
         port_hit[i] = (req_ff.port_number == 8'(i + 1));
      end
   end
   assign port_ok = |port_hit;

   always_comb begin
      op.set_feature   = advance && hub_cfg_ff && (req_ff.command == usbhp_pkg::CMD_SET_FEATURE);
      op.clear_feature = advance && hub_cfg_ff &&
                         (req_ff.command == usbhp_pkg::CMD_CLEAR_FEATURE);
      op.set_config    = advance && (req_ff.command == usbhp_pkg::CMD_SET_CONFIG);
      op.tick          = advance && (req_ff.command == usbhp_pkg::CMD_TICK);
      op.set_change    = advance && (req_ff.command == usbhp_pkg::CMD_SET_CHANGE);
      op.attach        = advance && (req_ff.command == usbhp_pkg::CMD_ATTACH);
      op.feature       = req_ff.feature;
      op.change_mask   = req_ff.change_mask;
      op.attached_flag = req_ff.attached_flag;
   end

   // port instances
   for (genvar g = 0; g < PORT_COUNT; g++) begin : g_port
      usbhp_port u_port (
         .clock        (clock),
         .reset        (reset),
         .settle_ticks (settle_ff),
         .sel          (port_hit[g]),
         .op           (op),
         .stat         (stat[g])
      );
   end

   // gather the selected status word and the change bitmap
   always_comb begin
      sel_word     = '0;
      port_chg_map = '0;
      for (int i = 0; i < PORT_COUNT; i++) begin
         sel_word          = sel_word | (port_hit[i] ? stat[i].status_word : 32'd0);
         port_chg_map[i + 1] = stat[i].any_change;
      end
   end

   // form the response
   always_comb begin
      rsp_in.status_code = usbhp_pkg::ST_OK;
      rsp_in.read_data   = '0;
      case (req_ff.command)
         usbhp_pkg::CMD_SET_FEATURE: begin
            if (!hub_cfg_ff || !port_ok) begin
               rsp_in.status_code = usbhp_pkg::ST_INVALID;
            end else if (req_ff.feature != usbhp_pkg::FEAT_RESET &&
                         req_ff.feature != usbhp_pkg::FEAT_SUSPEND &&
                         req_ff.feature != usbhp_pkg::FEAT_POWER) begin
               rsp_in.status_code = usbhp_pkg::ST_NOTSUP;
            end
         end
         usbhp_pkg::CMD_CLEAR_FEATURE: begin
            if (!hub_cfg_ff || !port_ok) begin
               rsp_in.status_code = usbhp_pkg::ST_INVALID;
            end else if (req_ff.feature != usbhp_pkg::FEAT_ENABLE &&
                         req_ff.feature != usbhp_pkg::FEAT_SUSPEND &&
                         req_ff.feature != usbhp_pkg::FEAT_POWER &&
                         (req_ff.feature < usbhp_pkg::FEAT_C_CONNECT ||
                          req_ff.feature > usbhp_pkg::FEAT_C_RESET)) begin
               rsp_in.status_code = usbhp_pkg::ST_NOTSUP;
            end
         end
         usbhp_pkg::CMD_PORT_STATUS: begin
            if (!hub_cfg_ff || !port_ok) begin
               rsp_in.status_code = usbhp_pkg::ST_INVALID;
            end else begin
               rsp_in.read_data = sel_word;
            end
         end
         usbhp_pkg::CMD_HUB_REQUEST: rsp_in.status_code = usbhp_pkg::ST_NOTSUP;
         usbhp_pkg::CMD_HUB_STATUS:  rsp_in.read_data   = '0;
         usbhp_pkg::CMD_CHANGE_MAP:  rsp_in.read_data   = port_chg_map;
         usbhp_pkg::CMD_SET_CONFIG:  rsp_in.status_code = usbhp_pkg::ST_OK;
         usbhp_pkg::CMD_TICK:        rsp_in.status_code = usbhp_pkg::ST_OK;
         usbhp_pkg::CMD_SET_CHANGE,
         usbhp_pkg::CMD_ATTACH: begin
            if (!port_ok) begin
               rsp_in.status_code = usbhp_pkg::ST_INVALID;
            end
         end
         default: rsp_in.status_code = usbhp_pkg::ST_NOTSUP;
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed request produced no response");

   a_stall_only_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (req_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a blocked response");

   a_no_bad_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.status_code != 2'd3))
      else $error("undefined status code");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status_code != usbhp_pkg::ST_OK) |-> (rsp_ff.read_data == 32'd0))
      else $error("error response carries data");

endmodule
